FILE: hdl/prz_pkg.sv
// Shared types, constants and state encoding for the point rotate / project block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package prz_pkg;
    localparam int SCREEN_WIDTH_DEF  = 120;
    localparam int SCREEN_HEIGHT_DEF = 40;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam logic [7:0] BLANK = 8'd32;
    localparam logic [23:0] INV_MAX = 24'hFFFFFF;

    typedef enum logic [2:0] {
        CFG_SIN_A  = 3'd0,
        CFG_COS_A  = 3'd1,
        CFG_SIN_B  = 3'd2,
        CFG_COS_B  = 3'd3,
        CFG_SIN_C  = 3'd4,
        CFG_COS_C  = 3'd5,
        CFG_CAM    = 3'd6,
        CFG_SCALE  = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ROT, S_DEPTH, S_DIV, S_PROJ, S_LOOK, S_WRITE, S_OUT
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic start_rot;
        logic rot_step;
        logic start_div;
        logic div_step;
        logic proj_step;
        logic look;
        logic write;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic rot_done;
        logic behind;
        logic div_done;
        logic proj_done;
        logic is_read;
    } t_sts;
endpackage
`default_nettype wire

FILE: hdl/prz_if.sv
// Valid/ready channel carrying a packed payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface prz_if #(parameter int W = 8) (input wire logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/point_rotate_project_zbuffer.sv
// Top level: point rotate, perspective project and depth buffer.
// Depends on prz_pkg, prz_if, prz_ctrl, prz_dp.
// Usage:
//  Input channel i_in carries {func, point_x, point_y, point_z, glyph, read_index};
//  output channel o_out carries {hit, screen_index, glyph_out}, one item per input.
//  A read item (func 1) returns a glyph and clears that pixel.
//  A plot runs 13 serial rotation terms of three or four phases each, a
//  depth check, a 39-step restoring divider, projection steps, lookup, write
//  and output load; a point behind the camera goes from the depth check
//  to output load, and a read goes straight to lookup, write and output load.
//  One item in flight; the next item is accepted the cycle after the result
//  loads.
//  Reset: the config and control registers return to defaults and a
//  clearing pass sweeps every address of both stores; no input is taken
//  until it ends. Config writes are taken at any time.
//  Stall: the result register holds until taken; one further item may be
//  accepted and computed meanwhile, then it waits and no input is taken.
`timescale 1ns / 1ps
`default_nettype none
module point_rotate_project_zbuffer
    import prz_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    prz_if.sink                       i_in,
    prz_if.source                     o_out
);
    t_cmd cmd;
    t_sts sts;
    logic r_ov;
    logic in_rdy;
    logic hit;
    logic [12:0] idx;
    logic [7:0] gl;

    prz_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(i_in.valid), .o_in_ready(in_rdy),
        .i_out_busy(r_ov && !o_out.ready),
        .i_sts(sts), .o_cmd(cmd)
    );
    assign i_in.ready = in_rdy;

    prz_dp #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_func(i_in.data[45]), .i_px(i_in.data[44:37]), .i_py(i_in.data[36:29]),
        .i_pz(i_in.data[28:21]), .i_glyph(i_in.data[20:13]),
        .i_read_index(i_in.data[12:0]),
        .i_cmd(cmd), .o_sts(sts), .o_hit(hit), .o_index(idx), .o_glyph(gl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (cmd.load_out) r_ov <= 1'b1;
        else if (o_out.ready) r_ov <= 1'b0;
    end
    assign o_out.valid = r_ov;
    assign o_out.data = {hit, idx, gl};
endmodule
`default_nettype wire

FILE: hdl/prz_ctrl.sv
// Sequencer for the block: clear sweep, rotate, divide, project, depth compare.
// Depends on prz_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prz_ctrl
    import prz_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire logic i_out_busy,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_sts.clr_done) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_ROT;
            S_ROT: begin
                if (i_sts.is_read) n_state = S_LOOK;
                else if (i_sts.rot_done) n_state = S_DEPTH;
            end
            S_DEPTH: n_state = i_sts.behind ? S_OUT : S_DIV;
            S_DIV:   if (i_sts.div_done) n_state = S_PROJ;
            S_PROJ:  if (i_sts.proj_done) n_state = S_LOOK;
            S_LOOK:  n_state = S_WRITE;
            S_WRITE: n_state = S_OUT;
            S_OUT:   if (!i_out_busy) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.start_rot = i_in_valid;
            end
            S_ROT:   o_cmd.rot_step = 1'b1;
            S_DEPTH: o_cmd.start_div = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_PROJ:  o_cmd.proj_step = 1'b1;
            S_LOOK:  o_cmd.look = 1'b1;
            S_WRITE: o_cmd.write = 1'b1;
            S_OUT:   o_cmd.load_out = !i_out_busy;
            default: ;
        endcase
    end

    ap_clear_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("input accepted during clear sweep");
    ap_write_after_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write |-> $past(o_cmd.look))
        else $error("store write without lookup");
    ap_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.rot_step, o_cmd.div_step, o_cmd.proj_step, o_cmd.clr_step}))
        else $error("two units stepped at once");
endmodule
`default_nettype wire

FILE: hdl/prz_dp.sv
// Datapath: config registers, serial rotation MAC, restoring divider,
// projection multiplies, glyph and depth memories. Depends on prz_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prz_dp
    import prz_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_func,
    input  wire logic signed [7:0]    i_px,
    input  wire logic signed [7:0]    i_py,
    input  wire logic signed [7:0]    i_pz,
    input  wire logic [7:0]           i_glyph,
    input  wire logic [12:0]          i_read_index,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    output logic                      o_hit,
    output logic [12:0]               o_index,
    output logic [7:0]                o_glyph
);
    localparam int PIX = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW  = $clog2(PIX);
    localparam int HW  = SCREEN_WIDTH / 2;
    localparam int HH  = SCREEN_HEIGHT / 2;

    logic signed [15:0] r_sa, r_ca, r_sb, r_cb, r_sc, r_cc;
    logic [9:0] r_cam;
    logic [7:0] r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa <= '0; r_ca <= 16'sd16384; r_sb <= '0; r_cb <= 16'sd16384;
            r_sc <= '0; r_cc <= 16'sd16384; r_cam <= 10'd250; r_scale <= 8'd40;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SIN_A: r_sa <= i_cfg_data;
                CFG_COS_A: r_ca <= i_cfg_data;
                CFG_SIN_B: r_sb <= i_cfg_data;
                CFG_COS_B: r_cb <= i_cfg_data;
                CFG_SIN_C: r_sc <= i_cfg_data;
                CFG_COS_C: r_cc <= i_cfg_data;
                CFG_CAM:   r_cam <= i_cfg_data[9:0];
                CFG_SCALE: r_scale <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // item latch
    logic r_func;
    logic signed [7:0] r_i, r_j, r_k;
    logic [7:0] r_gl;
    logic [12:0] r_ridx;
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_rot) begin
            r_func <= i_func; r_i <= i_px; r_j <= i_py; r_k <= i_pz;
            r_gl <= i_glyph; r_ridx <= i_read_index;
        end
    end

    // Rotation: products are formed pairwise as q = a*b (32b), then
    // q * c (48b cut: 16x32 as two halves is avoided by staging Q28 terms).
    // Terms per step: t = coord * f1 * f2 (* f3 optional), accumulated in Q42.
    // Step schedule: step s picks factors; one 16x8 then one 32x16 then, for
    // three-factor terms, one 40x16 multiply, each registered.
    logic [4:0]  r_step;
    logic [1:0]  r_ph;
    logic signed [63:0] r_x42, r_y42, r_z42;
    logic signed [31:0] r_p1;
    logic signed [55:0] r_p2;
    logic signed [15:0] f1, f2, f3;
    logic signed [7:0]  fc;
    logic [1:0] dst;
    logic three, neg;
    localparam int NTERM = 14;

    always_comb begin
        f1 = r_sa; f2 = r_sb; f3 = r_cc; fc = r_j; dst = 2'd0; three = 1'b1; neg = 1'b0;
        unique case (r_step)
            5'd0:  begin f1 = r_sa; f2 = r_sb; f3 = r_cc; fc = r_j; dst = 2'd0; end
            5'd1:  begin f1 = r_ca; f2 = r_sb; f3 = r_cc; fc = r_k; dst = 2'd0; neg = 1'b1; end
            5'd2:  begin f1 = r_ca; f2 = r_sc; fc = r_j; dst = 2'd0; three = 1'b0; end
            5'd3:  begin f1 = r_sa; f2 = r_sc; fc = r_k; dst = 2'd0; three = 1'b0; end
            5'd4:  begin f1 = r_cb; f2 = r_cc; fc = r_i; dst = 2'd0; three = 1'b0; end
            5'd5:  begin f1 = r_ca; f2 = r_cc; fc = r_j; dst = 2'd1; three = 1'b0; end
            5'd6:  begin f1 = r_sa; f2 = r_cc; fc = r_k; dst = 2'd1; three = 1'b0; end
            5'd7:  begin f1 = r_cb; f2 = r_sc; fc = r_i; dst = 2'd1; three = 1'b0;
                         neg = 1'b1; end
            5'd8:  begin f1 = r_sa; f2 = r_sb; f3 = r_sc; fc = r_j; dst = 2'd1;
                         neg = 1'b1; end
            5'd9:  begin f1 = r_ca; f2 = r_sb; f3 = r_sc; fc = r_k; dst = 2'd1; end
            5'd10: begin f1 = r_ca; f2 = r_cb; fc = r_k; dst = 2'd2; three = 1'b0; end
            5'd11: begin f1 = r_sa; f2 = r_cb; fc = r_j; dst = 2'd2; three = 1'b0;
                         neg = 1'b1; end
            default: begin f1 = r_sb; f2 = 16'sd16384; fc = r_i; dst = 2'd2; three = 1'b0; end
        endcase
    end

    logic signed [63:0] term;
    always_comb begin
        // two-factor terms carry an extra 2^14 to reach Q42
        if (three) term = 64'(r_p2) * 64'sd1;
        else       term = 64'(r_p2) <<< 14;
        if (r_step == 5'd12) term = 64'(r_p2) <<< 14;
        if (neg) term = -term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0; r_ph <= '0;
        end else if (i_cmd.start_rot) begin
            r_step <= '0; r_ph <= '0;
            r_x42 <= '0; r_y42 <= '0; r_z42 <= '0;
        end else if (i_cmd.rot_step) begin
            unique case (r_ph)
                2'd0: begin r_p1 <= 32'(f1) * 32'(fc); r_ph <= 2'd1; end
                2'd1: begin
                    r_p2 <= 56'(48'(r_p1) * 48'(f2));
                    r_ph <= three ? 2'd2 : 2'd3;
                end
                2'd2: begin
                    r_p2 <= 56'($signed(r_p2[39:0])) * 56'(f3);
                    r_ph <= 2'd3;
                end
                default: begin
                    unique case (dst)
                        2'd0: r_x42 <= r_x42 + term;
                        2'd1: r_y42 <= r_y42 + term;
                        default: r_z42 <= r_z42 + term;
                    endcase
                    r_ph <= 2'd0;
                    r_step <= r_step + 5'd1;
                end
            endcase
        end
    end
    assign o_sts.rot_done = (r_step == 5'(NTERM - 1)) && (r_ph == 2'd0);
    assign o_sts.is_read  = r_func;

    // Q42 -> Q14 floor is an arithmetic shift
    logic signed [35:0] x14, y14, z14;
    assign x14 = 36'(r_x42 >>> 28);
    assign y14 = 36'(r_y42 >>> 28);
    assign z14 = 36'(r_z42 >>> 28) + 36'({r_cam, 14'd0});
    assign o_sts.behind = (z14 <= 0);

    // restoring divide 2^38 / z, one quotient bit per cycle
    logic [38:0] r_rem;
    logic [38:0] r_quo;
    logic [35:0] r_den;
    logic [5:0]  r_dcnt;
    logic signed [35:0] r_x14, r_y14;
    logic [39:0] trial;
    assign trial = {r_rem[38:0], r_quo[38]} - {4'd0, r_den};
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_div) begin
            r_rem <= '0; r_quo <= 39'h40_0000_0000; r_den <= 36'(z14);
            r_dcnt <= 6'd39; r_x14 <= x14; r_y14 <= y14;
        end else if (i_cmd.div_step && r_dcnt != 0) begin
            if (!trial[39]) begin
                r_rem <= trial[38:0];
                r_quo <= {r_quo[37:0], 1'b1};
            end else begin
                r_rem <= {r_rem[37:0], r_quo[38]};
                r_quo <= {r_quo[37:0], 1'b0};
            end
            r_dcnt <= r_dcnt - 6'd1;
        end
    end
    assign o_sts.div_done = (r_dcnt == 0);
    logic [23:0] inv;
    assign inv = (r_quo > 39'(INV_MAX)) ? INV_MAX : r_quo[23:0];

    // projection over a few registered steps
    logic [2:0] r_pc;
    logic [31:0] r_kinv;
    logic signed [69:0] r_cn, r_rn;
    logic signed [31:0] r_col, r_row;
    logic signed [33:0] r_idx;
    localparam logic signed [69:0] ONE38 = 70'sd1 <<< 38;
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_div) r_pc <= '0;
        else if (i_cmd.proj_step) begin
            r_pc <= r_pc + 3'd1;
            unique case (r_pc)
                3'd0: r_kinv <= 32'(r_scale) * 32'(inv);
                3'd1: begin
                    r_cn <= 70'(70'(HW) * ONE38) + 70'(70'sd2 * $signed({1'b0, r_kinv})) * 70'(r_x14);
                    r_rn <= 70'(70'(HH) * ONE38) + 70'($signed({1'b0, r_kinv})) * 70'(r_y14);
                end
                3'd2: begin
                    r_col <= 32'(r_cn / ONE38);
                    r_row <= 32'(r_rn / ONE38);
                end
                default: r_idx <= 34'(r_col) + 34'(r_row) * 34'(SCREEN_WIDTH);
            endcase
        end
    end
    assign o_sts.proj_done = (r_pc == 3'd4);

    // stores
    logic [7:0]  m_gl [PIX];
    logic [23:0] m_dp [PIX];
    logic [AW-1:0] r_caddr;
    logic [7:0] r_rgl;
    logic [23:0] r_rdp;
    logic on_scr;
    logic [AW-1:0] addr;
    assign on_scr = r_func ? (r_ridx < 13'(PIX)) : (r_idx >= 0 && r_idx < 34'(PIX));
    assign addr = r_func ? AW'(r_ridx) : AW'(r_idx);
    logic wen;
    assign wen = i_cmd.clr_step || (i_cmd.write && on_scr && (r_func || inv > r_rdp));
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_caddr <= '0;
        else if (i_cmd.clr_step) r_caddr <= r_caddr + AW'(1);
        if (i_cmd.look) begin
            r_rgl <= m_gl[addr];
            r_rdp <= m_dp[addr];
        end
        if (wen) begin
            m_gl[i_cmd.clr_step ? r_caddr : addr] <= (i_cmd.clr_step || r_func) ? BLANK : r_gl;
            m_dp[i_cmd.clr_step ? r_caddr : addr] <= (i_cmd.clr_step || r_func) ? 24'd0 : inv;
        end
    end
    assign o_sts.clr_done = (r_caddr == AW'(PIX - 1));

    logic r_behind;
    logic r_ws;
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_div) r_behind <= o_sts.behind;
        if (i_cmd.start_rot) r_behind <= 1'b0;
        if (i_cmd.load_out) begin
            o_hit <= !r_behind && !r_func && on_scr && r_ws;
            o_index <= (!r_behind && on_scr) ? 13'(addr) : 13'd0;
            o_glyph <= (r_func && on_scr) ? r_rgl : 8'd0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) r_ws <= wen;
    end
endmodule
`default_nettype wire
